// ===== rtl/grid_dda_raycaster_macros.svh =====
// Assertion helpers for the raycaster RTL
`ifndef GRID_DDA_RAYCASTER_MACROS_SVH
`define GRID_DDA_RAYCASTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define GDR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid_dda_raycaster assertion failed");
// Next-cycle implication, checked outside reset
`define GDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid_dda_raycaster assertion failed");
`else
`define GDR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GDR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/gdr_pkg.sv =====
`default_nettype none
package gdr_pkg;

   // Fixed-point and geometry constants
   localparam int FRAC_BITS      = 16;
   localparam int SCREEN_COLUMNS = 1024;
   localparam int MAP_DIM        = 64;
   localparam int CELL_W         = 6;
   localparam int WALK_W         = CELL_W + 2;
   localparam int ADDR_W         = 2 * CELL_W;
   localparam int CAM_SHIFT      = FRAC_BITS + 1 - $clog2(SCREEN_COLUMNS);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_PLANE_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_PLANE_Y = 3'd5;

   localparam logic [21:0] RST_POSITION_X     = 22'd163840;
   localparam logic [21:0] RST_POSITION_Y     = 22'd163840;
   localparam logic [17:0] RST_DIRECTION_X    = 18'd65536;
   localparam logic [17:0] RST_DIRECTION_Y    = 18'd0;
   localparam logic [17:0] RST_CAMERA_PLANE_X = 18'd0;
   localparam logic [17:0] RST_CAMERA_PLANE_Y = 18'd43254;

   // Item kinds
   localparam logic KIND_MAP_WRITE = 1'b0;
   localparam logic KIND_CAST      = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [9:0]        column;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic              cell_is_wall;
   } req_type;

   typedef struct packed {
      logic [9:0]        result_column;
      logic [23:0]       wall_distance;
      logic              hit_side;
      logic [CELL_W-1:0] hit_cell_x;
      logic [CELL_W-1:0] hit_cell_y;
      logic              left_map;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/grid_dda_raycaster.sv =====
// Grid DDA raycaster with a 64 x 64 one-bit wall map.
// req_* carries transactions: kind 0 writes one map cell (no
// response); kind 1 casts the ray of one screen column and gives exactly one
// rsp_* transaction with wall distance, side, hit cell and a left-map flag.
// csr_* writes the six camera registers, one per transaction, always ready.
// A cast first runs its setup (camera products, two restoring reciprocal
// divisions on one shared divider, the side distance products) and then
// walks the grid; each step reads the wall map through its single
// synchronous port and tests the registered data in the cycle after.
// A step that leaves the map ends the walk without a map read; the result is then loaded.
// One cast is in flight at a time; the next transaction is taken once the
// result sits in the output register.
// After reset the map memory is swept to empty, one cell per cycle;
// req_ready stays low meanwhile, csr writes are still taken.
// If the receiver stalls, the result is held in the output register and a
// further cast finishes its walk and waits until that slot is free.
`default_nettype none
`include "grid_dda_raycaster_macros.svh"
module grid_dda_raycaster (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  gdr_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output gdr_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [gdr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [gdr_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int F      = gdr_pkg::FRAC_BITS;
   localparam int CW     = gdr_pkg::CELL_W;
   localparam int WW     = gdr_pkg::WALK_W;
   localparam int AW     = gdr_pkg::ADDR_W;
   localparam int RAY_W  = 21;
   localparam int DIV_STEPS = 2 * F + 1;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_CAMX  = 4'd2;
   localparam logic [3:0] ST_RAYX  = 4'd3;
   localparam logic [3:0] ST_RAYY  = 4'd4;
   localparam logic [3:0] ST_DIVX  = 4'd5;
   localparam logic [3:0] ST_DIVY  = 4'd6;
   localparam logic [3:0] ST_SIDEX = 4'd7;
   localparam logic [3:0] ST_SIDEY = 4'd8;
   localparam logic [3:0] ST_WALK  = 4'd9;
   localparam logic [3:0] ST_TEST  = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   // Camera registers
   logic        [21:0] pos_x_ff, pos_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   // Cast datapath
   logic [3:0]              state_ff, state_in;
   logic [9:0]              column_ff;
   logic signed [17:0]      cam_ff;
   logic signed [35:0]      prod_ff;
   logic signed [RAY_W-1:0] ray_x_ff, ray_y_ff;
   logic [RAY_W-1:0]        mag_ff, rem_ff;
   logic [DIV_STEPS-1:0]    quo_ff;
   logic [5:0]              cnt_ff;
   logic [31:0]             delta_x_ff, delta_y_ff, sdx_ff, sdy_ff;
   logic [WW-1:0]           cx_ff, cy_ff;
   logic                    side_ff, left_ff;
   logic [AW-1:0]           clr_cnt_ff;

   // Wall map
   logic          map_mem [2**AW];
   logic          mem_q_ff;
   logic          mem_we;
   logic          mem_wd;
   logic [AW-1:0] mem_addr;

   // Output register
   logic             rsp_valid_ff;
   gdr_pkg::rsp_type rsp_ff;

   // Combinational helpers
   logic                    req_acc;
   logic signed [17:0]      cam_in;
   logic signed [RAY_W-1:0] ray_sum;
   logic [RAY_W:0]          trial;
   logic                    qbit;
   logic [DIV_STEPS-1:0]    quo_in;
   logic [31:0]             delta_sat;
   logic [RAY_W-1:0]        abs_y;
   logic [F:0]              span;
   logic [48:0]             side_prod;
   logic [31:0]             side_sat;
   logic                    take_x;
   logic [32:0]             add_sum;
   logic [31:0]             add_sat;
   logic [WW-1:0]           nx, ny;
   logic                    out_of_map;
   logic [31:0]             fin_s, fin_d, fin_diff;
   logic [23:0]             fin_dist;
   logic                    rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Camera term: 2*column/SCREEN_COLUMNS - 1
   assign cam_in = $signed({1'b0, req_data.column, {gdr_pkg::CAM_SHIFT{1'b0}}})
                   - $signed(18'(1 << F));

   // Ray component from direction and floored plane product
   always_comb begin
      if (state_ff == ST_RAYX) begin
         ray_sum = RAY_W'(dir_x_ff) + RAY_W'($signed(prod_ff[35:F]));
      end else begin
         ray_sum = RAY_W'(dir_y_ff) + RAY_W'($signed(prod_ff[35:F]));
      end
   end

   // Restoring division of 2^(2F) by the ray magnitude, one bit per cycle
   assign trial  = {rem_ff, (cnt_ff == 6'd0)};
   assign qbit   = (trial >= {1'b0, mag_ff});
   assign quo_in = {quo_ff[DIV_STEPS-2:0], qbit};
   assign delta_sat = quo_in[DIV_STEPS-1] ? 32'hFFFF_FFFF : quo_in[31:0];
   assign abs_y  = ray_y_ff[RAY_W-1] ? RAY_W'(-ray_y_ff) : ray_y_ff;

   // Initial side distance: span to the next boundary times delta
   always_comb begin
      if (state_ff == ST_SIDEX) begin
         span      = ray_x_ff[RAY_W-1] ? {1'b0, pos_x_ff[F-1:0]}
                                       : (F+1)'(1 << F) - {1'b0, pos_x_ff[F-1:0]};
         side_prod = 49'(span) * 49'(delta_x_ff);
      end else begin
         span      = ray_y_ff[RAY_W-1] ? {1'b0, pos_y_ff[F-1:0]}
                                       : (F+1)'(1 << F) - {1'b0, pos_y_ff[F-1:0]};
         side_prod = 49'(span) * 49'(delta_y_ff);
      end
   end
   assign side_sat = side_prod[48] ? 32'hFFFF_FFFF :
                     (side_prod[F+32] ? 32'hFFFF_FFFF : side_prod[F+31:F]);

   // One DDA step: advance along the nearer boundary
   assign take_x  = (sdx_ff < sdy_ff);
   assign add_sum = take_x ? ({1'b0, sdx_ff} + {1'b0, delta_x_ff})
                           : ({1'b0, sdy_ff} + {1'b0, delta_y_ff});
   assign add_sat = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
   assign nx = take_x ? (cx_ff + (ray_x_ff[RAY_W-1] ? '1 : WW'(1))) : cx_ff;
   assign ny = take_x ? cy_ff : (cy_ff + (ray_y_ff[RAY_W-1] ? '1 : WW'(1)));
   assign out_of_map = (nx >= WW'(gdr_pkg::MAP_DIM)) || (ny >= WW'(gdr_pkg::MAP_DIM));

   // Perpendicular distance of the hit: side distance less one delta
   assign fin_s    = side_ff ? sdy_ff : sdx_ff;
   assign fin_d    = side_ff ? delta_y_ff : delta_x_ff;
   assign fin_diff = (fin_s >= fin_d) ? (fin_s - fin_d) : 32'd0;
   assign fin_dist = (fin_diff > 32'h00FF_FFFF) ? 24'hFF_FFFF : fin_diff[23:0];
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Map port: clearing sweep, cell writes, walk reads
   always_comb begin
      mem_we   = 1'b0;
      mem_wd   = 1'b0;
      mem_addr = {nx[CW-1:0], ny[CW-1:0]};
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
         end
         ST_IDLE: begin
            mem_we   = req_acc && (req_data.kind == gdr_pkg::KIND_MAP_WRITE);
            mem_wd   = req_data.cell_is_wall;
            mem_addr = {req_data.cell_x, req_data.cell_y};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_addr] <= mem_wd;
      end
      mem_q_ff <= map_mem[mem_addr];
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (req_acc && (req_data.kind == gdr_pkg::KIND_CAST)) state_in = ST_CAMX;
         ST_CAMX:  state_in = ST_RAYX;
         ST_RAYX:  state_in = ST_RAYY;
         ST_RAYY:  state_in = ST_DIVX;
         ST_DIVX:  if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_DIVY;
         ST_DIVY:  if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_SIDEX;
         ST_SIDEX: state_in = ST_SIDEY;
         ST_SIDEY: begin
            if ((WW'(pos_x_ff[21:F]) >= WW'(gdr_pkg::MAP_DIM)) ||
                (WW'(pos_y_ff[21:F]) >= WW'(gdr_pkg::MAP_DIM))) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK:  state_in = out_of_map ? ST_DONE : ST_TEST;
         ST_TEST:  state_in = mem_q_ff ? ST_DONE : ST_WALK;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Camera registers: take writes at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= gdr_pkg::RST_POSITION_X;
         pos_y_ff   <= gdr_pkg::RST_POSITION_Y;
         dir_x_ff   <= gdr_pkg::RST_DIRECTION_X;
         dir_y_ff   <= gdr_pkg::RST_DIRECTION_Y;
         plane_x_ff <= gdr_pkg::RST_CAMERA_PLANE_X;
         plane_y_ff <= gdr_pkg::RST_CAMERA_PLANE_Y;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gdr_pkg::CSR_POSITION_X:     pos_x_ff   <= csr_data;
            gdr_pkg::CSR_POSITION_Y:     pos_y_ff   <= csr_data;
            gdr_pkg::CSR_DIRECTION_X:    dir_x_ff   <= csr_data[17:0];
            gdr_pkg::CSR_DIRECTION_Y:    dir_y_ff   <= csr_data[17:0];
            gdr_pkg::CSR_CAMERA_PLANE_X: plane_x_ff <= csr_data[17:0];
            gdr_pkg::CSR_CAMERA_PLANE_Y: plane_y_ff <= csr_data[17:0];
            default: begin
            end
         endcase
      end
   end

   // Cast datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            column_ff <= req_data.column;
            cam_ff    <= cam_in;
         end
         ST_CAMX: prod_ff <= plane_x_ff * cam_ff;
         ST_RAYX: begin
            ray_x_ff <= ray_sum;
            prod_ff  <= plane_y_ff * cam_ff;
         end
         ST_RAYY: begin
            ray_y_ff <= ray_sum;
            mag_ff   <= ray_x_ff[RAY_W-1] ? RAY_W'(-ray_x_ff) : ray_x_ff;
            rem_ff   <= '0;
            quo_ff   <= '0;
            cnt_ff   <= '0;
         end
         ST_DIVX, ST_DIVY: begin
            rem_ff <= qbit ? RAY_W'(trial - {1'b0, mag_ff}) : trial[RAY_W-1:0];
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               // hand the divider over to the y component
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= '0;
               mag_ff <= abs_y;
               if (state_ff == ST_DIVX) begin
                  delta_x_ff <= delta_sat;
               end else begin
                  delta_y_ff <= delta_sat;
               end
            end
         end
         ST_SIDEX: sdx_ff <= side_sat;
         ST_SIDEY: begin
            sdy_ff  <= side_sat;
            cx_ff   <= WW'(pos_x_ff[21:F]);
            cy_ff   <= WW'(pos_y_ff[21:F]);
            side_ff <= 1'b0;
            left_ff <= 1'b1;
         end
         ST_WALK: begin
            if (take_x) begin
               sdx_ff <= add_sat;
            end else begin
               sdy_ff <= add_sat;
            end
            cx_ff   <= nx;
            cy_ff   <= ny;
            side_ff <= !take_x;
            left_ff <= out_of_map;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_ff.result_column <= column_ff;
               rsp_ff.left_map      <= left_ff;
               rsp_ff.wall_distance <= left_ff ? 24'd0 : fin_dist;
               rsp_ff.hit_side      <= left_ff ? 1'b0 : side_ff;
               rsp_ff.hit_cell_x    <= left_ff ? '0 : cx_ff[CW-1:0];
               rsp_ff.hit_cell_y    <= left_ff ? '0 : cy_ff[CW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Checks
   `GDR_ASSERT_IMPL(a_accept_idle, clock, reset, req_valid && req_ready, state_ff == ST_IDLE)
   `GDR_ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE)
   `GDR_ASSERT_IMPL(a_left_zero, clock, reset, rsp_valid && rsp_data.left_map, (rsp_data.wall_distance == 24'd0) && !rsp_data.hit_side)

endmodule
`default_nettype wire

// ===== tb/grid_dda_raycaster_test.sv =====
`default_nettype none
module grid_dda_raycaster_test;

   localparam longint SAT32      = 64'hFFFF_FFFF;
   localparam longint DIST_LIMIT = 64'hFF_FFFF;
   localparam int     STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   gdr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   gdr_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [gdr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gdr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   grid_dda_raycaster u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // camera registers and wall map as the block should hold them
   logic [21:0] cam_pos_x, cam_pos_y;
   logic signed [17:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
   bit walls [0:gdr_pkg::MAP_DIM*gdr_pkg::MAP_DIM-1];

   gdr_pkg::req_type pending_items[$];
   gdr_pkg::rsp_type expected_hits[$];
   int sender_idle_pct = 0, receiver_stall_pct = 0, hold_cycles = 0;
   int mismatches = 0, casts_seen = 0, walls_hit = 0, rays_lost = 0, map_writes = 0;
   int quiet_cycles = 0;
   bit req_taken = 1'b0;

   function automatic longint step_length(longint r);
      longint mag, q;
      if (r == 0) return SAT32;
      mag = r < 0 ? -r : r;
      q = (longint'(1) << (2 * gdr_pkg::FRAC_BITS)) / mag;
      return q > SAT32 ? SAT32 : q;
   endfunction

   function automatic longint first_boundary(longint r, logic [21:0] pos, longint delta);
      longint frac, span, v;
      frac = longint'(pos) & ((longint'(1) << gdr_pkg::FRAC_BITS) - 1);
      span = r < 0 ? frac : (longint'(1) << gdr_pkg::FRAC_BITS) - frac;
      v = (span * delta) >> gdr_pkg::FRAC_BITS;
      return v > SAT32 ? SAT32 : v;
   endfunction

   // walk the grid for one column and form the expected result
   function automatic gdr_pkg::rsp_type cast_ray(logic [9:0] column);
      longint cam, rx, ry, dx, dy, sx, sy, s, d, gap;
      int cx, cy, stx, sty;
      bit side, left;
      gdr_pkg::rsp_type r;
      cam = ((2 * longint'(column)) << gdr_pkg::FRAC_BITS) / gdr_pkg::SCREEN_COLUMNS
            - (longint'(1) << gdr_pkg::FRAC_BITS);
      rx = longint'(cam_dir_x) + ((longint'(cam_plane_x) * cam) >>> gdr_pkg::FRAC_BITS);
      ry = longint'(cam_dir_y) + ((longint'(cam_plane_y) * cam) >>> gdr_pkg::FRAC_BITS);
      dx = step_length(rx);
      dy = step_length(ry);
      stx = rx < 0 ? -1 : 1;
      sty = ry < 0 ? -1 : 1;
      sx = first_boundary(rx, cam_pos_x, dx);
      sy = first_boundary(ry, cam_pos_y, dy);
      cx = int'(cam_pos_x >> gdr_pkg::FRAC_BITS);
      cy = int'(cam_pos_y >> gdr_pkg::FRAC_BITS);
      side = 1'b0;
      left = 1'b0;
      gap = 0;
      if (cx >= gdr_pkg::MAP_DIM || cy >= gdr_pkg::MAP_DIM) begin
         left = 1'b1;
      end else begin
         forever begin
            if (sx < sy) begin
               sx = sx + dx > SAT32 ? SAT32 : sx + dx;
               cx += stx;
               side = 1'b0;
            end else begin
               sy = sy + dy > SAT32 ? SAT32 : sy + dy;
               cy += sty;
               side = 1'b1;
            end
            if (cx < 0 || cx >= gdr_pkg::MAP_DIM || cy < 0 || cy >= gdr_pkg::MAP_DIM) begin
               left = 1'b1;
               break;
            end
            if (walls[cx * gdr_pkg::MAP_DIM + cy]) break;
         end
      end
      r = '0;
      r.result_column = column;
      r.left_map = left;
      if (!left) begin
         s = side ? sy : sx;
         d = side ? dy : dx;
         gap = s >= d ? s - d : 0;
         r.wall_distance = 24'(gap > DIST_LIMIT ? DIST_LIMIT : gap);
         r.hit_side = side;
         r.hit_cell_x = cx[gdr_pkg::CELL_W-1:0];
         r.hit_cell_y = cy[gdr_pkg::CELL_W-1:0];
      end
      return r;
   endfunction

   // predict on each accepted request
   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_taken <= 1'b1;
         if (req_data.kind == gdr_pkg::KIND_MAP_WRITE) begin
            walls[req_data.cell_x * gdr_pkg::MAP_DIM + req_data.cell_y] = req_data.cell_is_wall;
            map_writes++;
         end else begin
            expected_hits.push_back(cast_ray(req_data.column));
         end
      end else begin
         req_taken <= 1'b0;
      end
   end

   // drive requests from the pending queue
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data = pending_items.pop_front();
            req_valid = 1'b1;
         end else begin
            req_valid = 1'b0;
         end
      end
   end

   // receiver back-pressure, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = !reset && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // check each response transaction against the oldest expectation
   always @(posedge clock) begin
      gdr_pkg::rsp_type want;
      if (rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: column %0d", rsp_data.result_column);
         end else begin
            want = expected_hits.pop_front();
            casts_seen++;
            if (rsp_data.left_map) rays_lost++; else walls_hit++;
            if (rsp_data.result_column !== want.result_column ||
                rsp_data.wall_distance !== want.wall_distance ||
                rsp_data.hit_side !== want.hit_side ||
                rsp_data.hit_cell_x !== want.hit_cell_x ||
                rsp_data.hit_cell_y !== want.hit_cell_y ||
                rsp_data.left_map !== want.left_map) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch col %0d: exp dist %h side %b cell %0d,%0d left %b",
                           want.result_column, want.wall_distance, want.hit_side,
                           want.hit_cell_x, want.hit_cell_y, want.left_map,
                           " / got col %0d dist %h side %b cell %0d,%0d left %b",
                           rsp_data.result_column, rsp_data.wall_distance,
                           rsp_data.hit_side, rsp_data.hit_cell_x,
                           rsp_data.hit_cell_y, rsp_data.left_map);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [gdr_pkg::CSR_IDX_W-1:0] idx,
                            logic [gdr_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         gdr_pkg::CSR_POSITION_X:     cam_pos_x = value;
         gdr_pkg::CSR_POSITION_Y:     cam_pos_y = value;
         gdr_pkg::CSR_DIRECTION_X:    cam_dir_x = value[17:0];
         gdr_pkg::CSR_DIRECTION_Y:    cam_dir_y = value[17:0];
         gdr_pkg::CSR_CAMERA_PLANE_X: cam_plane_x = value[17:0];
         gdr_pkg::CSR_CAMERA_PLANE_Y: cam_plane_y = value[17:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_camera(logic [21:0] px, logic [21:0] py, logic [17:0] dx,
                              logic [17:0] dy, logic [17:0] plx, logic [17:0] ply);
      write_reg(gdr_pkg::CSR_POSITION_X, px);
      write_reg(gdr_pkg::CSR_POSITION_Y, py);
      write_reg(gdr_pkg::CSR_DIRECTION_X, {4'b0, dx});
      write_reg(gdr_pkg::CSR_DIRECTION_Y, {4'b0, dy});
      write_reg(gdr_pkg::CSR_CAMERA_PLANE_X, {4'b0, plx});
      write_reg(gdr_pkg::CSR_CAMERA_PLANE_Y, {4'b0, ply});
   endtask

   task automatic add_map_write(int x, int y, bit wall);
      gdr_pkg::req_type it;
      it = '0;
      it.kind = gdr_pkg::KIND_MAP_WRITE;
      it.cell_x = gdr_pkg::CELL_W'(x);
      it.cell_y = gdr_pkg::CELL_W'(y);
      it.cell_is_wall = wall;
      it.column = 10'($urandom);
      pending_items.push_back(it);
   endtask

   task automatic add_cast(int col);
      gdr_pkg::req_type it;
      it = 24'($urandom);
      it.kind = gdr_pkg::KIND_CAST;
      it.column = 10'(col);
      pending_items.push_back(it);
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int sender_pcts[6] = '{0, 70, 0, 27, 0, 70};
      int stall_pcts[6]  = '{0, 0, 70, 27, 0, 70};
      cam_pos_x = gdr_pkg::RST_POSITION_X;
      cam_pos_y = gdr_pkg::RST_POSITION_Y;
      cam_dir_x = gdr_pkg::RST_DIRECTION_X;
      cam_dir_y = gdr_pkg::RST_DIRECTION_Y;
      cam_plane_x = gdr_pkg::RST_CAMERA_PLANE_X;
      cam_plane_y = gdr_pkg::RST_CAMERA_PLANE_Y;
      foreach (walls[i]) walls[i] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty map, edge columns, zero ray component, start cell wall
      add_cast(0);
      add_cast(1023);
      add_cast(512);
      add_map_write(2, 2, 1'b1);
      add_map_write(6, 2, 1'b1);
      add_cast(512);
      add_map_write(6, 2, 1'b0);
      add_map_write(63, 63, 1'b1);
      add_map_write(0, 0, 1'b1);
      add_map_write(63, 0, 1'b1);
      add_map_write(0, 63, 1'b1);
      add_cast(512);
      add_cast(0);
      add_cast(1023);
      add_cast(1);
      wait_idle();

      // tie of side distances along a diagonal, from a cell centre
      load_camera(22'h028000, 22'h028000, 18'h10000, 18'h10000, 18'h0, 18'h0);
      add_map_write(5, 5, 1'b1);
      add_cast(512);
      add_cast(700);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: load_camera(gdr_pkg::RST_POSITION_X, gdr_pkg::RST_POSITION_Y,
                           gdr_pkg::RST_DIRECTION_X, gdr_pkg::RST_DIRECTION_Y,
                           gdr_pkg::RST_CAMERA_PLANE_X, gdr_pkg::RST_CAMERA_PLANE_Y);
            1: load_camera(22'h0, 22'h0, 18'h20000, 18'h20000, 18'h20000, 18'h20000);
            2: load_camera(22'h3FFFFF, 22'h3FFFFF, 18'h1FFFF, 18'h1FFFF,
                           18'h1FFFF, 18'h1FFFF);
            default: load_camera(22'($urandom), 22'($urandom), 18'($urandom),
                                 18'($urandom), 18'($urandom), 18'($urandom));
         endcase
         sender_idle_pct = sender_pcts[p];
         receiver_stall_pct = stall_pcts[p];
         // scatter walls, then mix casts with more map edits
         repeat (50) add_map_write($urandom_range(63), $urandom_range(63),
                                   $urandom_range(99) < 85);
         for (int i = 0; i < 120; i++) begin
            if ($urandom_range(99) < 25)
               add_map_write($urandom_range(63), $urandom_range(63),
                             1'($urandom_range(1)));
            else
               add_cast($urandom_range(1023));
         end
         if (p == 4) begin
            @(negedge clock);
            hold_cycles = 2000;
         end
         wait_idle();
      end

      repeat (400) @(posedge clock);
      $display("covered %0d map writes and %0d casts: %0d hit a wall, %0d left the map",
               map_writes, casts_seen, walls_hit, rays_lost);
      if (mismatches == 0 && expected_hits.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
